@@ src/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_pkg - shared types and constants for the perspective point transform
// Fixed point format, datapath widths, sequencer states and control bundles.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + 2;
    localparam int CAP_SH    = DATA_W - FRAC_BITS;
    localparam int STEP_W    = $clog2(DATA_W);

    localparam int MAT_N     = 4;
    localparam int IDX_W     = 2;
    localparam int NUM_COORD = 3;

    localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [IDX_W-1:0]  COL_BIAS   = IDX_W'(MAT_N - 1);
    localparam logic [IDX_W-1:0]  LAST_ROW   = IDX_W'(MAT_N - 1);
    localparam logic [IDX_W-1:0]  LAST_COORD = IDX_W'(NUM_COORD - 1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DATA_W - 1);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_MUL,
        S_ACC,
        S_SAVE,
        S_CHK,
        S_DIV,
        S_DWAIT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_LOAD,
        D_RUN,
        D_FIN
    } t_div_state;

    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
    } t_mac_ctl;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] quot;
    } t_div_res;

endpackage

@@ src/point_transform_perspective.sv @@
// ----------------------------------------------------------------------------
// point_transform_perspective - 4x4 homogeneous point transform with divide
// Holds a Q16.16 matrix, transforms a point with implied w of 1 and divides
// x, y and z by the resulting w with saturation.
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken on the rising edge where start is high and busy is
//   low. i_mode selects an element write (i_row, i_col, i_element) or a point
//   transform (i_point_x, i_point_y, i_point_z).
//   an element write completes on that same edge, busy stays low and no
//   result is produced.
//   a point transform raises busy and runs twelve multiply-accumulates on one
//   shared multiplier, then three divisions on one shared bit-serial divider
//   (one quotient bit per cycle). o_done pulses for one cycle with the
//   result; when w is zero the divisions are skipped. busy is low again in
//   the cycle o_done is high, so a new transaction can be taken in that cycle.
//   results are valid only in the cycle o_done is high;
//   the receiver has no stall, o_done is a single-cycle strobe.
//   reset loads the identity matrix and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module point_transform_perspective (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [ptp_pkg::IDX_W-1:0]         i_row,
    input  logic [ptp_pkg::IDX_W-1:0]         i_col,
    input  logic signed [ptp_pkg::DATA_W-1:0] i_element,
    input  logic signed [ptp_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [ptp_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [ptp_pkg::DATA_W-1:0] i_point_z,
    output logic                              o_done,
    output logic signed [ptp_pkg::DATA_W-1:0] o_out_x,
    output logic signed [ptp_pkg::DATA_W-1:0] o_out_y,
    output logic signed [ptp_pkg::DATA_W-1:0] o_out_z,
    output logic                              o_w_zero,
    output logic                              o_overflow
);
    import ptp_pkg::*;

    t_state r_state, n_state;

    logic [IDX_W-1:0]         r_row, n_row;
    logic [IDX_W-1:0]         r_col, n_col;
    logic [IDX_W-1:0]         r_k, n_k;
    logic signed [DATA_W-1:0] r_mat [0:MAT_N-1][0:MAT_N-1];
    logic signed [DATA_W-1:0] r_pt  [0:NUM_COORD-1];
    logic signed [ACC_W-1:0]  r_acc [0:MAT_N-1];
    logic signed [DATA_W-1:0] r_q   [0:NUM_COORD-1];
    logic                     r_wz;
    logic                     r_ovf;
    logic                     r_done;

    t_mac_ctl                 mac_ctl;
    logic                     div_start;
    t_div_res                 div_res;
    logic [IDX_W-1:0]         rd_col;
    logic signed [DATA_W-1:0] coef;
    logic signed [DATA_W-1:0] coord;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mat_we;
    logic                     pt_we;
    logic                     save;
    logic                     q_we;
    logic                     done_set;
    logic                     w_is_zero;

    assign rd_col    = (r_state == S_ROW) ? COL_BIAS : r_col;
    assign coef      = r_mat[r_row][rd_col];
    assign coord     = r_pt[r_col];
    assign w_is_zero = (r_acc[LAST_ROW] == '0);

    ptp_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_coef  (coef),
        .i_coord (coord),
        .o_acc   (mac_acc)
    );

    ptp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc[r_k]),
        .i_den   (r_acc[LAST_ROW]),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_done  <= done_set;
        end
    end

    // matrix store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAT_N; r++) begin
                for (int c = 0; c < MAT_N; c++) begin
                    r_mat[r][c] <= (r == c) ? FIX_ONE : '0;
                end
            end
        end else if (mat_we) begin
            r_mat[i_row][i_col] <= i_element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt[0] <= i_point_x;
            r_pt[1] <= i_point_y;
            r_pt[2] <= i_point_z;
        end
        if (save) begin
            r_acc[r_row] <= mac_acc;
        end
        if (r_state == S_CHK) begin
            r_wz  <= w_is_zero;
            r_ovf <= 1'b0;
            if (w_is_zero) begin
                for (int i = 0; i < NUM_COORD; i++) begin
                    r_q[i] <= '0;
                end
            end
        end
        if (q_we) begin
            r_q[r_k] <= div_res.quot;
            r_ovf    <= r_ovf | div_res.sat;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        mac_ctl   = '0;
        div_start = 1'b0;
        mat_we    = 1'b0;
        pt_we     = 1'b0;
        save      = 1'b0;
        q_we      = 1'b0;
        done_set  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode == MODE_XFORM) begin
                        pt_we   = 1'b1;
                        n_row   = '0;
                        n_state = S_ROW;
                    end else begin
                        mat_we = 1'b1;
                    end
                end
            end
            S_ROW: begin
                mac_ctl.clear = 1'b1;
                n_col         = '0;
                n_state       = S_MUL;
            end
            S_MUL: begin
                mac_ctl.mul = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                mac_ctl.acc = 1'b1;
                if (r_col == LAST_COORD) begin
                    n_state = S_SAVE;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_SAVE: begin
                save = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = S_CHK;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_ROW;
                end
            end
            S_CHK: begin
                n_k = '0;
                if (w_is_zero) begin
                    done_set = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_res.done) begin
                    q_we = 1'b1;
                    if (r_k == LAST_COORD) begin
                        done_set = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_out_x    = r_q[0];
    assign o_out_y    = r_q[1];
    assign o_out_z    = r_q[2];
    assign o_w_zero   = r_wz;
    assign o_overflow = r_ovf;

    // zero w gives zero coordinates and no overflow
    a_wzero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_w_zero) |-> (o_out_x == '0 && o_out_y == '0 &&
                                  o_out_z == '0 && !o_overflow))
        else $error("w_zero result carries nonzero data");

    // result strobe only once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a transform transaction starts the sequencer
    a_xform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_XFORM) |=> busy)
        else $error("transform accepted without going busy");

    // an element write neither blocks nor produces a result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_WRITE) |=> (!busy && !o_done))
        else $error("element write produced a result or went busy");

endmodule

@@ src/ptp_mac.sv @@
// ----------------------------------------------------------------------------
// ptp_mac - shared multiply-accumulate unit
// One signed multiply per step, registered, then floor-shifted and added into
// a wide accumulator that is preloaded with the translation term.
// ----------------------------------------------------------------------------
module ptp_mac (
    input  logic                                i_clk,
    input  ptp_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [ptp_pkg::DATA_W-1:0]   i_coef,
    input  logic signed [ptp_pkg::DATA_W-1:0]   i_coord,
    output logic signed [ptp_pkg::ACC_W-1:0]    o_acc
);
    import ptp_pkg::*;

    localparam int EXT_W = ACC_W - (PROD_W - FRAC_BITS);

    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  prod_sh;

    always_comb begin
        prod_sh = {{EXT_W{r_prod[PROD_W-1]}}, r_prod[PROD_W-1:FRAC_BITS]};
        n_prod  = r_prod;
        n_acc   = r_acc;
        if (i_ctl.mul) begin
            n_prod = PROD_W'(i_coef) * PROD_W'(i_coord);
        end
        if (i_ctl.clear) begin
            n_acc = {{(ACC_W-DATA_W){i_coef[DATA_W-1]}}, i_coef};
        end else if (i_ctl.acc) begin
            n_acc = r_acc + prod_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

@@ src/ptp_div.sv @@
// ----------------------------------------------------------------------------
// ptp_div - iterative signed fixed point divider
// Restoring division of |num| * 2^FRAC_BITS by |den|, one quotient bit per
// cycle, with truncation toward zero and saturation to the signed data width.
// ----------------------------------------------------------------------------
module ptp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ptp_pkg::ACC_W-1:0]  i_num,
    input  logic signed [ptp_pkg::ACC_W-1:0]  i_den,
    output ptp_pkg::t_div_res                 o_res
);
    import ptp_pkg::*;

    t_div_state r_state, n_state;

    logic [ACC_W-1:0]  r_a, n_a;
    logic [ACC_W-1:0]  r_b, n_b;
    logic [ACC_W-1:0]  r_rem, n_rem;
    logic [DATA_W-1:0] r_dq, n_dq;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_cap, n_cap;
    t_div_res          r_res, n_res;
    logic [ACC_W:0]    trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_neg <= n_neg;
        r_cap <= n_cap;
    end

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_rem    = r_rem;
        n_dq     = r_dq;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_cap    = r_cap;
        n_res    = r_res;
        n_res.done = 1'b0;
        trial    = {r_rem, r_dq[DATA_W-1]} - {1'b0, r_b};
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_a     = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
                    n_b     = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
                    n_neg   = i_num[ACC_W-1] ^ i_den[ACC_W-1];
                    n_state = D_LOAD;
                end
            end
            D_LOAD: begin
                n_cap   = {{CAP_SH{1'b0}}, r_a} >= {r_b, {CAP_SH{1'b0}}};
                n_rem   = r_a >> CAP_SH;
                n_dq    = {r_a[CAP_SH-1:0], {FRAC_BITS{1'b0}}};
                n_cnt   = '0;
                n_state = D_RUN;
            end
            D_RUN: begin
                if (!trial[ACC_W]) begin
                    n_rem = trial[ACC_W-1:0];
                    n_dq  = {r_dq[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[ACC_W-2:0], r_dq[DATA_W-1]};
                    n_dq  = {r_dq[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = D_FIN;
                end
            end
            D_FIN: begin
                n_res.done = 1'b1;
                if (r_cap) begin
                    n_res.sat  = 1'b1;
                    n_res.quot = r_neg ? SAT_NEG : SAT_POS;
                end else if (r_neg) begin
                    n_res.sat  = r_dq > SAT_NEG;
                    n_res.quot = (r_dq > SAT_NEG) ? SAT_NEG : DATA_W'(-r_dq);
                end else begin
                    n_res.sat  = r_dq[DATA_W-1];
                    n_res.quot = r_dq[DATA_W-1] ? SAT_POS : r_dq;
                end
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the perspective point transform
// Feeds element writes and point transforms through the start/busy command
// port, keeps a shadow copy of the matrix, predicts each projected point with
// its saturation and zero-w flags, and checks every o_done strobe in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ptp_pkg::*;

    typedef struct {
        logic              mode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] element;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [DATA_W-1:0] pz;
        int unsigned       hold_pct;
    } t_command;

    typedef struct {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              w_zero;
        logic              overflow;
    } t_projection;

    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 160;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic                     i_mode     = MODE_WRITE;
    logic [IDX_W-1:0]         i_row      = '0;
    logic [IDX_W-1:0]         i_col      = '0;
    logic signed [DATA_W-1:0] i_element  = '0;
    logic signed [DATA_W-1:0] i_point_x  = '0;
    logic signed [DATA_W-1:0] i_point_y  = '0;
    logic signed [DATA_W-1:0] i_point_z  = '0;
    logic                     busy;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_out_x;
    logic signed [DATA_W-1:0] o_out_y;
    logic signed [DATA_W-1:0] o_out_z;
    logic                     o_w_zero;
    logic                     o_overflow;

    t_command    command_q[$];
    t_projection projected_q[$];
    logic signed [DATA_W-1:0] shadow_matrix [MAT_N][MAT_N];

    int unsigned phase_hold    = 0;
    int unsigned xform_issued  = 0;
    int unsigned results_seen  = 0;
    int unsigned writes_taken  = 0;
    int unsigned zero_w_seen   = 0;
    int unsigned saturated_seen = 0;
    int unsigned mismatch_count = 0;

    point_transform_perspective dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_mode     (i_mode),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_element  (i_element),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_point_z  (i_point_z),
        .o_done     (o_done),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z),
        .o_w_zero   (o_w_zero),
        .o_overflow (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic logic [DATA_W-1:0] rand_fixed();
        int unsigned pick;
        int          v;
        pick = $urandom_range(99);
        if (pick < 40) begin
            v = int'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        end else if (pick < 60) begin
            v = int'($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        end else if (pick < 85) begin
            v = int'($urandom);
        end else begin
            case ($urandom_range(6))
                0: v = 0;
                1: v = int'(FIX_ONE);
                2: v = -int'(FIX_ONE);
                3: v = int'(SAT_POS);
                4: v = int'(SAT_NEG);
                5: v = 1;
                default: v = -1;
            endcase
        end
        return DATA_W'(v);
    endfunction

    task automatic push_write(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                              input logic [DATA_W-1:0] value);
        t_command cmd;
        cmd.mode     = MODE_WRITE;
        cmd.row      = r;
        cmd.col      = c;
        cmd.element  = value;
        cmd.px       = $urandom;
        cmd.py       = $urandom;
        cmd.pz       = $urandom;
        cmd.hold_pct = phase_hold;
        command_q.push_back(cmd);
    endtask

    task automatic push_xform(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                              input logic [DATA_W-1:0] z);
        t_command cmd;
        cmd.mode     = MODE_XFORM;
        cmd.row      = IDX_W'($urandom);
        cmd.col      = IDX_W'($urandom);
        cmd.element  = $urandom;
        cmd.px       = x;
        cmd.py       = y;
        cmd.pz       = z;
        cmd.hold_pct = phase_hold;
        command_q.push_back(cmd);
    endtask

    // num * 2^FRAC_BITS / den, truncated toward zero, clipped to 32 bits
    function automatic logic [DATA_W-1:0] divide_fixed(input longint num, input longint den,
                                                       output logic clipped);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q0;
        logic [63:0] r;
        logic [63:0] q;
        logic        neg;
        int          i;
        a       = (num < 0) ? 64'(-num) : 64'(num);
        b       = (den < 0) ? 64'(-den) : 64'(den);
        neg     = (num < 0) != (den < 0);
        clipped = 1'b0;
        q0      = a / b;
        r       = a % b;
        if (q0 > (64'd1 << CAP_SH)) begin
            q0 = 64'd1 << CAP_SH;
        end
        q = q0 << FRAC_BITS;
        for (i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            if (r >= b) begin
                r = r - b;
                q[FRAC_BITS-1-i] = 1'b1;
            end
        end
        if (neg) begin
            if (q > 64'h8000_0000) begin
                clipped = 1'b1;
                return SAT_NEG;
            end
            return DATA_W'(~q + 64'd1);
        end
        if (q > 64'h7FFF_FFFF) begin
            clipped = 1'b1;
            return SAT_POS;
        end
        return DATA_W'(q);
    endfunction

    function automatic t_projection project_point(input logic [DATA_W-1:0] px,
                                                  input logic [DATA_W-1:0] py,
                                                  input logic [DATA_W-1:0] pz);
        longint      sum [MAT_N];
        longint      coord [NUM_COORD];
        t_projection res;
        logic        clip_x;
        logic        clip_y;
        logic        clip_z;
        int          r;
        int          c;
        coord[0] = longint'($signed(px));
        coord[1] = longint'($signed(py));
        coord[2] = longint'($signed(pz));
        for (r = 0; r < MAT_N; r++) begin
            sum[r] = longint'(shadow_matrix[r][COL_BIAS]);
            for (c = 0; c < NUM_COORD; c++) begin
                sum[r] += (longint'(shadow_matrix[r][c]) * coord[c]) >>> FRAC_BITS;
            end
        end
        if (sum[3] == 0) begin
            res.x        = '0;
            res.y        = '0;
            res.z        = '0;
            res.w_zero   = 1'b1;
            res.overflow = 1'b0;
        end else begin
            res.x        = divide_fixed(sum[0], sum[3], clip_x);
            res.y        = divide_fixed(sum[1], sum[3], clip_y);
            res.z        = divide_fixed(sum[2], sum[3], clip_z);
            res.w_zero   = 1'b0;
            res.overflow = clip_x | clip_y | clip_z;
        end
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        t_command cmd;
        int       r;
        int       c;
        if (!i_rst_n) begin
            start <= 1'b0;
            for (r = 0; r < MAT_N; r++) begin
                for (c = 0; c < MAT_N; c++) begin
                    shadow_matrix[r][c] = (r == c) ? FIX_ONE : '0;
                end
            end
        end else begin
            if (start && !busy) begin
                cmd = command_q.pop_front();
                if (cmd.mode == MODE_WRITE) begin
                    shadow_matrix[cmd.row][cmd.col] = cmd.element;
                    writes_taken++;
                end else begin
                    projected_q.push_back(project_point(cmd.px, cmd.py, cmd.pz));
                    xform_issued <= xform_issued + 1;
                end
            end
            if (start && busy) begin
                // hold the pending transaction
            end else if (command_q.size() != 0 &&
                         $urandom_range(99) >= command_q[0].hold_pct) begin
                i_mode    <= command_q[0].mode;
                i_row     <= command_q[0].row;
                i_col     <= command_q[0].col;
                i_element <= command_q[0].element;
                i_point_x <= command_q[0].px;
                i_point_y <= command_q[0].py;
                i_point_z <= command_q[0].pz;
                start     <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_proc
        t_projection want;
        if (i_rst_n && o_done) begin
            if (results_seen >= xform_issued) begin
                report_mismatch("result strobe with no transform outstanding");
            end else begin
                want = projected_q.pop_front();
                results_seen++;
                if (want.w_zero) zero_w_seen++;
                if (want.overflow) saturated_seen++;
                if (o_out_x !== want.x)
                    report_mismatch($sformatf("result %0d out_x %h want %h",
                                              results_seen, o_out_x, want.x));
                if (o_out_y !== want.y)
                    report_mismatch($sformatf("result %0d out_y %h want %h",
                                              results_seen, o_out_y, want.y));
                if (o_out_z !== want.z)
                    report_mismatch($sformatf("result %0d out_z %h want %h",
                                              results_seen, o_out_z, want.z));
                if (o_w_zero !== want.w_zero)
                    report_mismatch($sformatf("result %0d w_zero %b want %b",
                                              results_seen, o_w_zero, want.w_zero));
                if (o_overflow !== want.overflow)
                    report_mismatch($sformatf("result %0d overflow %b want %b",
                                              results_seen, o_overflow, want.overflow));
            end
        end
    end

    initial begin : stim_proc
        int          base;
        int          n;
        int          k;
        int unsigned pick;
        logic [DATA_W-1:0] one_neg;
        one_neg = DATA_W'(-int'(FIX_ONE));

        // directed part, identity matrix after reset
        phase_hold = 0;
        push_xform(FIX_ONE, DATA_W'(2 * int'(FIX_ONE)), DATA_W'(-3 * int'(FIX_ONE)));
        push_xform(SAT_POS, SAT_NEG, '0);
        // tiny w drives the divide into saturation both ways
        push_write(LAST_ROW, COL_BIAS, DATA_W'(1));
        push_xform(FIX_ONE, '0, '0);
        push_xform(one_neg, SAT_POS, DATA_W'(1));
        // negative w
        push_write(LAST_ROW, COL_BIAS, one_neg);
        push_xform(DATA_W'(2 * int'(FIX_ONE)), DATA_W'(-3 * int'(FIX_ONE)), DATA_W'(32768));
        // zero w
        push_write(LAST_ROW, COL_BIAS, '0);
        push_xform(DATA_W'(12345), DATA_W'(-777), SAT_NEG);
        push_write(LAST_ROW, 2'd0, FIX_ONE);
        push_xform('0, SAT_POS, SAT_POS);
        push_xform(FIX_ONE, DATA_W'(5 * int'(FIX_ONE)), DATA_W'(-7 * int'(FIX_ONE)));
        // extreme elements
        push_write(2'd0, 2'd0, SAT_POS);
        push_write(2'd0, 2'd1, SAT_NEG);
        push_write(2'd0, COL_BIAS, SAT_NEG);
        push_write(LAST_ROW, COL_BIAS, SAT_POS);
        push_xform(SAT_NEG, SAT_POS, SAT_POS);
        // back to identity
        push_write(2'd0, 2'd0, FIX_ONE);
        push_write(2'd0, 2'd1, '0);
        push_write(2'd0, COL_BIAS, '0);
        push_write(LAST_ROW, 2'd0, '0);
        push_write(LAST_ROW, COL_BIAS, FIX_ONE);
        push_xform(DATA_W'(-98765), DATA_W'(3 * int'(FIX_ONE)), DATA_W'(1));

        // random part in idling phases
        base = command_q.size();
        while (command_q.size() - base < RANDOM_ITEMS) begin
            n = command_q.size() - base;
            if (n < 400) phase_hold = 0;
            else if (n < 850) phase_hold = 74;
            else phase_hold = 14;
            pick = $urandom_range(99);
            if (pick < 8) begin
                // full matrix load, affine or perspective w row
                for (k = 0; k < MAT_N * NUM_COORD; k++) begin
                    push_write(IDX_W'(k / MAT_N), IDX_W'(k % MAT_N), rand_fixed());
                end
                if ($urandom_range(1)) begin
                    for (k = 0; k < NUM_COORD; k++) push_write(LAST_ROW, IDX_W'(k), '0);
                    push_write(LAST_ROW, COL_BIAS, FIX_ONE);
                end else begin
                    for (k = 0; k < MAT_N; k++) push_write(LAST_ROW, IDX_W'(k), rand_fixed());
                end
                push_xform(rand_fixed(), rand_fixed(), rand_fixed());
            end else if (pick < 13) begin
                // w depends on x alone, then x of zero
                push_write(LAST_ROW, 2'd1, '0);
                push_write(LAST_ROW, 2'd2, '0);
                push_write(LAST_ROW, COL_BIAS, '0);
                push_xform('0, rand_fixed(), rand_fixed());
                push_xform(rand_fixed(), rand_fixed(), rand_fixed());
            end else if (pick < 18) begin
                push_write(IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end else begin
                n = $urandom_range(3);
                for (k = 0; k < n; k++) begin
                    push_write(IDX_W'($urandom), IDX_W'($urandom), rand_fixed());
                end
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    push_xform(rand_fixed(), rand_fixed(), rand_fixed());
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (command_q.size() != 0 || projected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d element writes and %0d point transforms", writes_taken,
                 results_seen);
        $display("of the transforms %0d had zero w and %0d saturated", zero_w_seen,
                 saturated_seen);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #(8 * 1000000);
        $display("tb_top failed");
        $finish;
    end

endmodule
